FILE: hdl/lmps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmps_pkg;

	localparam int TPC_W   = 16;
	localparam int STEP_W  = 9;
	localparam int LVL_W   = 8;
	localparam int DRV_W   = 8;
	localparam int CELL_W  = 3;
	localparam int TIME_W  = 32;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 16;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [TPC_W-1:0]  TPC_RESET   = 16'd100;
	localparam logic [STEP_W-1:0] STEPS_RESET = 9'd256;
	localparam logic [STEP_W-1:0] STEPS_MIN   = 9'd2;
	localparam logic [STEP_W-1:0] STEPS_MAX   = 9'd256;

	localparam logic MODE_REFRESH = 1'b0;
	localparam logic MODE_WRITE   = 1'b1;

	localparam logic REG_TICKS = 1'b0;
	localparam logic REG_STEPS = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MOD  = 6'b000010,
		ST_COL  = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_ROWS = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

endpackage

`default_nettype wire

FILE: hdl/lmps_store.sv
`timescale 1ns / 1ps
`default_nettype none

module lmps_store import lmps_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [LVL_W-1:0] wr_level,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [LVL_W-1:0] rd_level
);

	logic [LVL_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [LVL_W-1:0] rd_data_q;
	logic             rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_level;
		end
		rd_data_q  <= mem[rd_addr];
		rd_valid_q <= valid_q[rd_addr];
	end

	// unwritten cells read as dark
	assign rd_level = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

FILE: hdl/lamp_matrix_pwm_scanner_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Lamp matrix scanner with a brightness level per lamp. A write word (tuser high) stores one
// cell's level, saturated to pwm_steps-1, and is taken with no result. A refresh word (tuser
// low) carries a time; the block reduces it modulo ticks_per_column*COLUMNS with a shared
// compare-subtract unit one time bit per cycle, splits the remainder into column and offset
// with max(clog2(COLUMNS),1) more steps, then reads the column's levels from the pattern
// store one row per cycle and compares them against the offset on a shared 16x8 multiplier.
// A refresh then raises its result word, and the block is ready for a new word in the cycle
// that the result word appears; it takes no new word meanwhile.
// The result waits in an output register, so a new word may be taken while it is pending; a
// refresh that finishes while the previous result still waits holds in its last step.
// The pattern store reads as dark after reset through per-cell valid bits, with no clearing
// pass. Only the first eight columns and rows have drive bits and writable cells.

module lamp_matrix_pwm_scanner_unit import lmps_pkg::*; #(
	parameter int COLUMNS   = 8,
	parameter int ROWS      = 8,
	parameter int TIME_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// now[31:0], cell_column[34:32], cell_row[37:35], cell_level[45:38], zero[47:46]
	input  wire logic [S_DATA_W-1:0] s_tdata,
	// mode
	input  wire logic                s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// column_drive[7:0], row_drive[15:8]
	output logic      [M_DATA_W-1:0] m_tdata,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [APB_AW-1:0]   paddr,
	input  wire logic [APB_DW-1:0]   pwdata,
	output logic      [APB_DW-1:0]   prdata,
	output logic                     pready
);

	localparam int SC    = (COLUMNS < 8) ? COLUMNS : 8;
	localparam int SR    = (ROWS < 8) ? ROWS : 8;
	localparam int DEPTH = SC * SR;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RB    = (SR > 1) ? $clog2(SR) : 1;
	localparam int CB    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int PER_W = TPC_W + CB;
	localparam int RW    = PER_W + 1;
	localparam int TB    = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
	localparam int TCW   = $clog2(TB);
	localparam int PW    = TPC_W + LVL_W;

	state_t              state_q;
	logic [TPC_W-1:0]    tpc_q;
	logic [STEP_W-1:0]   steps_q;
	logic [TCW-1:0]      bit_cnt_q;
	logic [CB-1:0]       col_i_q;
	logic [RB-1:0]       r_q;
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic [TB-1:0]       now_q;
	logic [RW-1:0]       rem_q;
	logic [CB-1:0]       col_q;
	logic [PW-1:0]       lhs_q;
	logic [SR-1:0]       rows_q;

	logic                cfg_wr;
	logic [TPC_W-1:0]    eff_tpc;
	logic [LVL_W-1:0]    top;
	logic [PER_W-1:0]    period;
	logic [TIME_W-1:0]   in_now;
	logic [CELL_W-1:0]   in_col;
	logic [CELL_W-1:0]   in_row;
	logic [LVL_W-1:0]    in_level;
	logic                s_hs;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [LVL_W-1:0]    wr_level;
	logic [AW-1:0]       rd_addr;
	logic [LVL_W-1:0]    rd_level;
	logic                col_in;
	logic [CB-1:0]       col_lo;
	logic [RB-1:0]       rd_row;
	logic [RW-1:0]       sub_a;
	logic [RW-1:0]       sub_b;
	logic [RW:0]         diff;
	logic                ge;
	logic [RW-1:0]       rem_nx;
	logic [TPC_W-1:0]    mul_a;
	logic [LVL_W-1:0]    mul_b;
	logic [PW-1:0]       prod;
	logic [LVL_W-1:0]    sat;
	logic                lamp_on;
	logic                out_free;
	logic [DRV_W-1:0]    col_drive;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_TICKS: prdata = APB_DW'(tpc_q);
			REG_STEPS: prdata = APB_DW'(steps_q);
			default:   prdata = '0;
		endcase
	end

	assign eff_tpc = (tpc_q == '0) ? TPC_W'(1) : tpc_q;

	always_comb begin
		priority if (steps_q < STEPS_MIN) begin
			top = LVL_W'(STEPS_MIN - 9'd1);
		end else if (steps_q > STEPS_MAX) begin
			top = LVL_W'(STEPS_MAX - 9'd1);
		end else begin
			top = LVL_W'(steps_q - 9'd1);
		end
	end

	assign period = PER_W'(eff_tpc) * PER_W'(COLUMNS);

	// input word fields
	assign in_now   = s_tdata[31:0];
	assign in_col   = s_tdata[34:32];
	assign in_row   = s_tdata[37:35];
	assign in_level = s_tdata[45:38];

	assign s_tready = (state_q == ST_IDLE);
	assign s_hs     = s_tvalid && s_tready;

	// pattern store access
	assign wr_en    = s_hs && (s_tuser == MODE_WRITE) &&
	                  (4'(in_col) < 4'(SC)) && (4'(in_row) < 4'(SR));
	assign wr_addr  = AW'(AW'(in_col) * AW'(SR)) + AW'(in_row);
	assign wr_level = (in_level > top) ? top : in_level;

	assign col_in = (6'(col_q) < 6'(SC));
	assign col_lo = col_in ? col_q : '0;
	assign rd_row = (state_q == ST_ROWS && r_q != RB'(SR - 1)) ? RB'(r_q + RB'(1)) :
	                (state_q == ST_ROWS) ? r_q : '0;
	assign rd_addr = AW'(AW'(col_lo) * AW'(SR)) + AW'(rd_row);

	lmps_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_level(wr_level),
		.rd_addr (rd_addr),
		.rd_level(rd_level)
	);

	// shared compare-subtract unit
	assign sub_a  = (state_q == ST_MOD) ? {rem_q[RW-2:0], now_q[TB-1]} : rem_q;
	assign sub_b  = (state_q == ST_MOD) ? RW'(period) : (RW'(eff_tpc) << col_i_q);
	assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge     = ~diff[RW];
	assign rem_nx = ge ? diff[RW-1:0] : sub_a;

	// shared multiplier: (offset+1)*top once, then level*ticks per row
	assign sat   = (rd_level > top) ? top : rd_level;
	assign mul_a = (state_q == ST_MUL) ? TPC_W'(rem_q[TPC_W-1:0] + TPC_W'(1)) : eff_tpc;
	assign mul_b = (state_q == ST_MUL) ? top : sat;
	assign prod  = PW'(mul_a) * PW'(mul_b);

	assign lamp_on  = col_in && (lhs_q <= prod);
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		for (int c = 0; c < DRV_W; c++) begin
			col_drive[c] = (6'(col_q) == 6'(c));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tpc_q      <= TPC_RESET;
			steps_q    <= STEPS_RESET;
			bit_cnt_q  <= '0;
			col_i_q    <= '0;
			r_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_TICKS: tpc_q   <= pwdata[TPC_W-1:0];
					REG_STEPS: steps_q <= pwdata[STEP_W-1:0];
					default:   tpc_q   <= tpc_q;
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_hs && s_tuser == MODE_REFRESH) begin
						bit_cnt_q <= TCW'(TB - 1);
						state_q   <= ST_MOD;
					end
				end
				ST_MOD: begin
					bit_cnt_q <= bit_cnt_q - TCW'(1);
					if (bit_cnt_q == '0) begin
						col_i_q <= CB'(CB - 1);
						state_q <= ST_COL;
					end
				end
				ST_COL: begin
					col_i_q <= col_i_q - CB'(1);
					if (col_i_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					r_q     <= '0;
					state_q <= ST_ROWS;
				end
				ST_ROWS: begin
					r_q <= RB'(r_q + RB'(1));
					if (r_q == RB'(SR - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_hs && s_tuser == MODE_REFRESH) begin
					now_q <= in_now[TB-1:0];
					rem_q <= '0;
					col_q <= '0;
				end
			end
			ST_MOD: begin
				rem_q <= rem_nx;
				now_q <= now_q << 1;
			end
			ST_COL: begin
				rem_q <= rem_nx;
				col_q <= CB'({col_q, ge});
			end
			ST_MUL: begin
				lhs_q <= prod;
			end
			ST_ROWS: begin
				rows_q[r_q] <= lamp_on;
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {DRV_W'(rows_q), col_drive};
				end
			end
			default: rem_q <= rem_q;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result word raised outside the finishing step");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == MODE_REFRESH) |=> (state_q == ST_MOD))
		else $error("refresh word did not start the modulo pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROWS) |-> (rem_q < RW'(eff_tpc)))
		else $error("column offset not below ticks per column");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[DRV_W-1:0]))
		else $error("column drive has more than one bit set");
`endif

endmodule

`default_nettype wire
